/* src/bdcc_pkg.sv */
// ----------------------------------------------------------------------------
// bdcc_pkg - shared types and constants for the button click classifier
// Request and result layouts, event codes, register indexes and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package bdcc_pkg;

    // Event codes held in the pending slot and returned on consume
    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_CLICK  = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } t_event;

    // Request kinds carried in tuser
    localparam logic REQ_UPDATE  = 1'b0;
    localparam logic REQ_CONSUME = 1'b1;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_WINDOW = 2'd2;

    localparam int unsigned CFG_W  = 16;
    localparam int unsigned TIME_W = 32;

    localparam logic [CFG_W-1:0] DEBOUNCE_RST      = 16'd50;
    localparam logic [CFG_W-1:0] LONG_PRESS_RST    = 16'd1000;
    localparam logic [CFG_W-1:0] DOUBLE_WINDOW_RST = 16'd300;

    // Stream widths
    localparam int unsigned S_TDATA_W = 40;
    localparam int unsigned M_TDATA_W = 8;

    typedef struct packed {
        logic                   req_type;
        logic                   pin_level;
        logic [TIME_W-1:0]      now_ms;
    } t_req;

    typedef struct packed {
        t_event                 event_code;
        logic                   pressed_level;
    } t_res;

    typedef struct packed {
        logic                   we;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_W-1:0]       data;
    } t_cfg_wr;

endpackage

`default_nettype wire

/* src/bdcc_in_stage.sv */
// ----------------------------------------------------------------------------
// bdcc_in_stage - input request register
// Holds one request from the slave side until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module bdcc_in_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire bdcc_pkg::t_req i_req,
    input  wire logic          i_take,
    output logic               o_ready,
    output logic               o_valid,
    output bdcc_pkg::t_req     o_req
);

    logic           r_valid;
    bdcc_pkg::t_req r_req;

    // room when empty or when the held request leaves this cycle
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_req   = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_req <= i_req;
        end
    end

endmodule

`default_nettype wire

/* src/bdcc_core.sv */
// ----------------------------------------------------------------------------
// bdcc_core - debounce and click classification state
// Applies one request per cycle, when i_fire is high, to the button state and forms its result.
// ----------------------------------------------------------------------------
`default_nettype none

module bdcc_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire bdcc_pkg::t_cfg_wr i_cfg,
    input  wire logic              i_fire,
    input  wire bdcc_pkg::t_req    i_req,
    output bdcc_pkg::t_res         o_res
);

    localparam int unsigned TW = bdcc_pkg::TIME_W;
    localparam int unsigned CW = bdcc_pkg::CFG_W;

    logic [CW-1:0]     r_debounce;
    logic [CW-1:0]     r_long_press;
    logic [CW-1:0]     r_window;

    logic              r_last_raw;
    logic [TW-1:0]     r_change_time;
    logic              r_stable;
    logic [TW-1:0]     r_press_start;
    logic              r_window_open;
    logic [TW-1:0]     r_release_stamp;
    bdcc_pkg::t_event  r_pending;

    logic              n_last_raw;
    logic [TW-1:0]     n_change_time;
    logic              n_stable;
    logic [TW-1:0]     n_press_start;
    logic              n_window_open;
    logic [TW-1:0]     n_release_stamp;
    bdcc_pkg::t_event  n_pending;

    logic              raw;
    logic              changed;
    logic              opened;
    logic [TW-1:0]     since_change;
    logic [TW-1:0]     hold;
    logic [TW-1:0]     since_release;
    logic [TW-1:0]     window_age;
    logic [TW-1:0]     debounce_x;
    logic [TW-1:0]     long_x;
    logic [TW-1:0]     window_x;

    assign debounce_x    = {{(TW-CW){1'b0}}, r_debounce};
    assign long_x        = {{(TW-CW){1'b0}}, r_long_press};
    assign window_x      = {{(TW-CW){1'b0}}, r_window};

    assign raw           = !i_req.pin_level;
    assign changed       = raw != r_last_raw;
    assign since_change  = changed ? '0 : i_req.now_ms - r_change_time;
    assign hold          = i_req.now_ms - r_press_start;
    assign since_release = i_req.now_ms - r_release_stamp;

    always_comb begin
        n_last_raw      = r_last_raw;
        n_change_time   = r_change_time;
        n_stable        = r_stable;
        n_press_start   = r_press_start;
        n_window_open   = r_window_open;
        n_release_stamp = r_release_stamp;
        n_pending       = r_pending;
        opened          = 1'b0;
        o_res.event_code = bdcc_pkg::EV_NONE;

        if (i_fire) begin
            if (i_req.req_type == bdcc_pkg::REQ_CONSUME) begin
                o_res.event_code = r_pending;
                n_pending        = bdcc_pkg::EV_NONE;
            end else begin
                n_last_raw = raw;
                if (changed) begin
                    n_change_time = i_req.now_ms;
                end
                if (since_change >= debounce_x) begin
                    n_stable = raw;
                end
                if (n_stable && !r_stable) begin
                    n_press_start = i_req.now_ms;
                end
                // debounced release: classify the hold
                if (!n_stable && r_stable) begin
                    if (hold >= long_x) begin
                        n_pending     = bdcc_pkg::EV_LONG;
                        n_window_open = 1'b0;
                    end else if (hold >= debounce_x) begin
                        if (r_window_open && since_release <= window_x) begin
                            n_pending     = bdcc_pkg::EV_DOUBLE;
                            n_window_open = 1'b0;
                        end else begin
                            n_release_stamp = i_req.now_ms;
                            n_window_open   = 1'b1;
                            opened          = 1'b1;
                        end
                    end
                end
            end
        end

        // expire the window; a fresh one has age zero
        window_age = opened ? '0 : since_release;
        if (i_fire && i_req.req_type == bdcc_pkg::REQ_UPDATE && n_window_open
            && window_age >= window_x) begin
            n_window_open = 1'b0;
            if (n_pending == bdcc_pkg::EV_NONE) begin
                n_pending = bdcc_pkg::EV_CLICK;
            end
        end

        o_res.pressed_level = n_stable;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce   <= bdcc_pkg::DEBOUNCE_RST;
            r_long_press <= bdcc_pkg::LONG_PRESS_RST;
            r_window     <= bdcc_pkg::DOUBLE_WINDOW_RST;
        end else if (i_cfg.we) begin
            case (i_cfg.idx)
                bdcc_pkg::CFG_DEBOUNCE:      r_debounce   <= i_cfg.data;
                bdcc_pkg::CFG_LONG_PRESS:    r_long_press <= i_cfg.data;
                bdcc_pkg::CFG_DOUBLE_WINDOW: r_window     <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_raw      <= 1'b0;
            r_change_time   <= '0;
            r_stable        <= 1'b0;
            r_press_start   <= '0;
            r_window_open   <= 1'b0;
            r_release_stamp <= '0;
            r_pending       <= bdcc_pkg::EV_NONE;
        end else begin
            r_last_raw      <= n_last_raw;
            r_change_time   <= n_change_time;
            r_stable        <= n_stable;
            r_press_start   <= n_press_start;
            r_window_open   <= n_window_open;
            r_release_stamp <= n_release_stamp;
            r_pending       <= n_pending;
        end
    end

`ifndef SYNTHESIS
    a_consume_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_req.req_type == bdcc_pkg::REQ_CONSUME)
        |=> r_pending == bdcc_pkg::EV_NONE)
        else $error("pending event survived a consume request");

    a_consume_keeps_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_req.req_type == bdcc_pkg::REQ_CONSUME)
        |=> r_stable == $past(r_stable))
        else $error("consume request changed the debounced level");

    a_press_stamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !r_stable && n_stable)
        |=> r_press_start == $past(i_req.now_ms))
        else $error("press start not taken from the pressing request");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> (r_pending == $past(r_pending) && r_window_open == $past(r_window_open)))
        else $error("button state moved without a request");
`endif

endmodule

`default_nettype wire

/* src/bdcc_out_stage.sv */
// ----------------------------------------------------------------------------
// bdcc_out_stage - result register
// Holds one result on the master side until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module bdcc_out_stage (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_load,
    input  wire bdcc_pkg::t_res i_res,
    input  wire logic           i_ready,
    output logic                o_valid,
    output bdcc_pkg::t_res      o_res
);

    logic           r_valid;
    bdcc_pkg::t_res r_res;

    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

/* src/button_debounce_click_classifier_unit.sv */
// ----------------------------------------------------------------------------
// button_debounce_click_classifier_unit - push-button debouncer and classifier
// Debounces one active-low button and reports clicks, double clicks and
// long presses through a pending event slot read by consume requests.
//
//   channel   dir  handshake              payload
//   s_axis    in   s_axis_tvalid/tready   tuser: req_type
//                                         tdata: pin_level, now_ms
//   m_axis    out  m_axis_tvalid/tready   tdata: event_code, pressed_level
//   cfg       in   i_cfg_we               i_cfg_idx, i_cfg_data
//
// Each request passes through the input register and then the result register;
// a new request is taken every cycle while the result side is not stalled. The
// state update (three 32-bit subtract and compare paths) sets the cycle time.
// Reset is synchronous and restores the register defaults. A stalled result
// register holds the core; the input register then fills.
// ----------------------------------------------------------------------------
`default_nettype none

module button_debounce_click_classifier_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // [0] pin_level, [32:1] now_ms, [39:33] zero
    input  wire logic [bdcc_pkg::S_TDATA_W-1:0]      s_axis_tdata,
    // [0] req_type
    input  wire logic                                s_axis_tuser,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // [1:0] event_code, [2] pressed_level, [7:3] zero
    output logic [bdcc_pkg::M_TDATA_W-1:0]           m_axis_tdata,
    input  wire logic                                i_cfg_we,
    input  wire logic [bdcc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  wire logic [bdcc_pkg::CFG_W-1:0]          i_cfg_data
);

    bdcc_pkg::t_req    s_req;
    bdcc_pkg::t_req    held_req;
    bdcc_pkg::t_res    core_res;
    bdcc_pkg::t_res    out_res;
    bdcc_pkg::t_cfg_wr cfg;
    logic              held_valid;
    logic              fire;

    assign s_req.req_type  = s_axis_tuser;
    assign s_req.pin_level = s_axis_tdata[0];
    assign s_req.now_ms    = s_axis_tdata[bdcc_pkg::TIME_W:1];

    assign cfg.we   = i_cfg_we;
    assign cfg.idx  = i_cfg_idx;
    assign cfg.data = i_cfg_data;

    // advance the held request when the result register has room
    assign fire = held_valid && (!m_axis_tvalid || m_axis_tready);

    bdcc_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_req   (s_req),
        .i_take  (fire),
        .o_ready (s_axis_tready),
        .o_valid (held_valid),
        .o_req   (held_req)
    );

    bdcc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_fire  (fire),
        .i_req   (held_req),
        .o_res   (core_res)
    );

    bdcc_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire),
        .i_res   (core_res),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_res   (out_res)
    );

    assign m_axis_tdata = {{(bdcc_pkg::M_TDATA_W-3){1'b0}},
                           out_res.pressed_level, out_res.event_code};

endmodule

`default_nettype wire

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb - self-checking bench for button_debounce_click_classifier_unit
// Drives update and consume requests over the input stream and predicts
// every result with an in-bench model of the debouncer and click classifier.
// A short directed run walks through click, double-click and long-press
// gestures. Randomised phases then follow under different register settings,
// the extremes among them. Both stream sides idle at random. One long
// receiver hold-off is included.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    localparam int unsigned CYCLE_LIMIT = 200000;

    typedef enum logic [1:0] {
        OP_REQ,
        OP_CFG,
        OP_PAUSE
    } t_op_kind;

    typedef struct {
        t_op_kind                       kind;
        bdcc_pkg::t_req                 rq;
        logic [bdcc_pkg::CFG_IDX_W-1:0] idx;
        logic [bdcc_pkg::CFG_W-1:0]     val;
    } t_op;

    typedef struct {
        logic                        last_raw;
        logic [bdcc_pkg::TIME_W-1:0] changed_at;
        logic                        pressed;
        logic [bdcc_pkg::TIME_W-1:0] press_at;
        logic                        win_open;
        logic [bdcc_pkg::TIME_W-1:0] released_at;
        bdcc_pkg::t_event            pending;
    } t_button;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    // [0] pin_level, [32:1] now_ms
    logic [bdcc_pkg::S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                            s_axis_tuser = 1'b0; // [0] req_type
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // [1:0] event_code, [2] pressed_level
    logic [bdcc_pkg::M_TDATA_W-1:0]  m_axis_tdata;
    logic                            i_cfg_we = 1'b0;
    logic [bdcc_pkg::CFG_IDX_W-1:0]  i_cfg_idx = bdcc_pkg::CFG_DEBOUNCE;
    logic [bdcc_pkg::CFG_W-1:0]      i_cfg_data = '0;

    button_debounce_click_classifier_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Button model: state, settings and one request step
    // ------------------------------------------------------------------------
    t_button                    btn;
    logic [bdcc_pkg::CFG_W-1:0] debounce_cfg;
    logic [bdcc_pkg::CFG_W-1:0] long_press_cfg;
    logic [bdcc_pkg::CFG_W-1:0] window_cfg;

    function automatic void clear_button();
        btn.last_raw    = 1'b0;
        btn.changed_at  = '0;
        btn.pressed     = 1'b0;
        btn.press_at    = '0;
        btn.win_open    = 1'b0;
        btn.released_at = '0;
        btn.pending     = bdcc_pkg::EV_NONE;
        debounce_cfg    = bdcc_pkg::DEBOUNCE_RST;
        long_press_cfg  = bdcc_pkg::LONG_PRESS_RST;
        window_cfg      = bdcc_pkg::DOUBLE_WINDOW_RST;
    endfunction

    function automatic bdcc_pkg::t_res classify_request(bdcc_pkg::t_req rq);
        bdcc_pkg::t_res              rs;
        logic                        raw;
        logic                        was_pressed;
        logic [bdcc_pkg::TIME_W-1:0] age;
        logic [bdcc_pkg::TIME_W-1:0] held;
        rs.event_code = bdcc_pkg::EV_NONE;
        if (rq.req_type == bdcc_pkg::REQ_UPDATE) begin
            raw = ~rq.pin_level;
            was_pressed = btn.pressed;
            if (raw != btn.last_raw) begin
                btn.last_raw = raw;
                btn.changed_at = rq.now_ms;
            end
            age = rq.now_ms - btn.changed_at;
            if (age >= {16'd0, debounce_cfg})
                btn.pressed = raw;
            if (btn.pressed && !was_pressed)
                btn.press_at = rq.now_ms;
            if (!btn.pressed && was_pressed) begin
                held = rq.now_ms - btn.press_at;
                age = rq.now_ms - btn.released_at;
                if (held >= {16'd0, long_press_cfg}) begin
                    btn.pending = bdcc_pkg::EV_LONG;
                    btn.win_open = 1'b0;
                end else if (held >= {16'd0, debounce_cfg}) begin
                    if (btn.win_open && age <= {16'd0, window_cfg}) begin
                        btn.pending = bdcc_pkg::EV_DOUBLE;
                        btn.win_open = 1'b0;
                    end else begin
                        btn.released_at = rq.now_ms;
                        btn.win_open = 1'b1;
                    end
                end
            end
            // close an expired window, posting a click if nothing waits
            age = rq.now_ms - btn.released_at;
            if (btn.win_open && age >= {16'd0, window_cfg}) begin
                btn.win_open = 1'b0;
                if (btn.pending == bdcc_pkg::EV_NONE)
                    btn.pending = bdcc_pkg::EV_CLICK;
            end
        end else begin
            rs.event_code = btn.pending;
            btn.pending = bdcc_pkg::EV_NONE;
        end
        rs.pressed_level = btn.pressed;
        return rs;
    endfunction

    // ------------------------------------------------------------------------
    // Request plan, filled before the run starts
    // ------------------------------------------------------------------------
    t_op                         stim_q[$];
    logic [bdcc_pkg::TIME_W-1:0] clock_ms = '0;
    int unsigned                 plan_deb = bdcc_pkg::DEBOUNCE_RST;
    int unsigned                 plan_long = bdcc_pkg::LONG_PRESS_RST;
    int unsigned                 plan_win = bdcc_pkg::DOUBLE_WINDOW_RST;
    int unsigned                 reqs_planned = 0;

    task automatic push_update(input logic pin, input logic [bdcc_pkg::TIME_W-1:0] dt);
        t_op op;
        clock_ms += dt;
        op.kind = OP_REQ;
        op.rq.req_type = bdcc_pkg::REQ_UPDATE;
        op.rq.pin_level = pin;
        op.rq.now_ms = clock_ms;
        op.idx = bdcc_pkg::CFG_DEBOUNCE;
        op.val = '0;
        stim_q.push_back(op);
        reqs_planned++;
    endtask

    // pin and time are don't-care on consume, so fill them with noise
    task automatic push_consume();
        t_op op;
        op.kind = OP_REQ;
        op.rq.req_type = bdcc_pkg::REQ_CONSUME;
        op.rq.pin_level = 1'($urandom_range(0, 1));
        op.rq.now_ms = $urandom;
        op.idx = bdcc_pkg::CFG_DEBOUNCE;
        op.val = '0;
        stim_q.push_back(op);
        reqs_planned++;
    endtask

    task automatic push_pause();
        t_op op;
        op.kind = OP_PAUSE;
        op.rq = '0;
        op.idx = bdcc_pkg::CFG_DEBOUNCE;
        op.val = '0;
        stim_q.push_back(op);
    endtask

    task automatic push_setting(input logic [bdcc_pkg::CFG_IDX_W-1:0] idx,
                                input int unsigned val);
        t_op op;
        op.kind = OP_CFG;
        op.rq = '0;
        op.idx = idx;
        op.val = bdcc_pkg::CFG_W'(val);
        stim_q.push_back(op);
        case (idx)
            bdcc_pkg::CFG_DEBOUNCE:   plan_deb = val;
            bdcc_pkg::CFG_LONG_PRESS: plan_long = val;
            default:                  plan_win = val;
        endcase
    endtask

    // press, hold, release and settle, with contact bounce at both ends
    task automatic add_gesture();
        int unsigned hold;
        int unsigned gap;
        int unsigned spent;
        int unsigned step;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 2)
            hold = $urandom_range(0, plan_deb);
        else if (pick < 7)
            hold = (plan_long > plan_deb) ? $urandom_range(plan_deb, plan_long - 1) : plan_deb;
        else
            hold = plan_long + $urandom_range(0, plan_long / 2 + 20);
        case ($urandom_range(0, 2))
            0:       gap = $urandom_range(0, plan_win / 3);
            1:       gap = $urandom_range(plan_win / 2, plan_win + plan_win / 2);
            default: gap = plan_win * 2 + $urandom_range(0, 100);
        endcase

        repeat ($urandom_range(0, 3))
            push_update(1'($urandom_range(0, 1)), $urandom_range(0, plan_deb / 2));
        push_update(1'b0, $urandom_range(1, 20));
        spent = 0;
        while (spent < hold) begin
            step = $urandom_range(1, hold / 4 + 1);
            push_update(1'b0, step);
            spent += step;
        end
        repeat ($urandom_range(0, 2))
            push_update(1'($urandom_range(0, 1)), $urandom_range(0, plan_deb / 2));
        push_update(1'b1, $urandom_range(1, 20));
        spent = 0;
        while (spent < gap + plan_deb) begin
            step = $urandom_range(1, (gap + plan_deb) / 4 + 1);
            push_update(1'b1, step);
            spent += step;
        end
        if ($urandom_range(0, 99) < 35)
            push_consume();
    endtask

    // stray samples: time jumps in both directions and bursts of consumes
    task automatic add_noise();
        case ($urandom_range(0, 4))
            0:       push_consume();
            1:       push_update(1'($urandom_range(0, 1)), $urandom);
            2:       push_update(1'($urandom_range(0, 1)), 32'hFFFF_FFFF - $urandom_range(0, 499));
            3:       push_update(1'($urandom_range(0, 1)), $urandom_range(0, 3));
            default: repeat ($urandom_range(1, 3)) push_consume();
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------------
    bdcc_pkg::t_res pending_results[$];
    logic           req_taken = 1'b0;
    logic           stim_done = 1'b0;
    int unsigned    reqs_sent = 0;

    always @(negedge i_clk) begin : drive_requests
        logic                           nv;
        logic [bdcc_pkg::S_TDATA_W-1:0] nd;
        logic                           nu;
        logic                           nwe;
        logic [bdcc_pkg::CFG_IDX_W-1:0] nidx;
        logic [bdcc_pkg::CFG_W-1:0]     ndat;
        logic                           quiet;
        t_op                            op;
        nv = s_axis_tvalid;
        nd = s_axis_tdata;
        nu = s_axis_tuser;
        nwe = 1'b0;
        nidx = i_cfg_idx;
        ndat = i_cfg_data;
        quiet = (reqs_sent >= 1100 && reqs_sent < 1400);
        if (i_rst_n && (!s_axis_tvalid || req_taken)) begin
            nv = 1'b0;
            if (stim_q.size() == 0) begin
                stim_done <= 1'b1;
            end else begin
                op = stim_q[0];
                case (op.kind)
                    OP_REQ: begin
                        if (quiet || $urandom_range(0, 99) >= 8) begin
                            nv = 1'b1;
                            nd = {7'd0, op.rq.now_ms, op.rq.pin_level};
                            nu = op.rq.req_type;
                            void'(stim_q.pop_front());
                            reqs_sent++;
                        end
                    end
                    OP_CFG: begin
                        // write only once the block has drained
                        if (pending_results.size() == 0) begin
                            nwe = 1'b1;
                            nidx = op.idx;
                            ndat = op.val;
                            void'(stim_q.pop_front());
                        end
                    end
                    default: begin
                        if (pending_results.size() == 0)
                            void'(stim_q.pop_front());
                    end
                endcase
            end
        end
        s_axis_tvalid <= nv;
        s_axis_tdata <= nd;
        s_axis_tuser <= nu;
        i_cfg_we <= nwe;
        i_cfg_idx <= nidx;
        i_cfg_data <= ndat;
    end

    // ------------------------------------------------------------------------
    // Result receiver with random stalls and one long hold-off
    // ------------------------------------------------------------------------
    int unsigned results_seen = 0;
    int unsigned hold_left = 0;
    logic        held_once = 1'b0;

    always @(negedge i_clk) begin : drive_ready
        logic nr;
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            nr = 1'b0;
        end else if (!held_once && results_seen >= 820) begin
            hold_left <= 150;
            held_once <= 1'b1;
            nr = 1'b0;
        end else if (results_seen >= 1100 && results_seen < 1400) begin
            nr = 1'b1;
        end else begin
            nr = ($urandom_range(0, 99) >= 8);
        end
        m_axis_tready <= nr;
    end

    // ------------------------------------------------------------------------
    // Port monitor: register writes, request capture and result checks
    // ------------------------------------------------------------------------
    int unsigned fail_count = 0;
    int unsigned reqs_taken = 0;
    int unsigned consumes_taken = 0;
    int unsigned settings_written = 0;
    int unsigned events_returned[4] = '{0, 0, 0, 0};

    always @(posedge i_clk) begin : watch_ports
        bdcc_pkg::t_res seen;
        bdcc_pkg::t_res want;
        bdcc_pkg::t_req rq;
        req_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (!i_rst_n) begin
            clear_button();
        end else begin
            if (i_cfg_we) begin
                settings_written++;
                case (i_cfg_idx)
                    bdcc_pkg::CFG_DEBOUNCE:      debounce_cfg = i_cfg_data;
                    bdcc_pkg::CFG_LONG_PRESS:    long_press_cfg = i_cfg_data;
                    bdcc_pkg::CFG_DOUBLE_WINDOW: window_cfg = i_cfg_data;
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                seen.event_code = bdcc_pkg::t_event'(m_axis_tdata[1:0]);
                seen.pressed_level = m_axis_tdata[2];
                results_seen <= results_seen + 1;
                if (pending_results.size() == 0) begin
                    $error("result with no request outstanding: tdata 0x%0h", m_axis_tdata);
                    fail_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (seen.event_code !== want.event_code) begin
                        $error("event_code: expected %0d, got %0d",
                               want.event_code, seen.event_code);
                        fail_count++;
                    end
                    if (seen.pressed_level !== want.pressed_level) begin
                        $error("pressed_level: expected %0d, got %0d",
                               want.pressed_level, seen.pressed_level);
                        fail_count++;
                    end
                    if (want.event_code != bdcc_pkg::EV_NONE
                        || seen.event_code == want.event_code)
                        events_returned[want.event_code]++;
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                rq.req_type = s_axis_tuser;
                rq.pin_level = s_axis_tdata[0];
                rq.now_ms = s_axis_tdata[32:1];
                pending_results.push_back(classify_request(rq));
                reqs_taken++;
                if (rq.req_type == bdcc_pkg::REQ_CONSUME)
                    consumes_taken++;
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        int unsigned cycles;
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_results.size());
            $display("tb NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus plan, reset and end of run
    // ------------------------------------------------------------------------
    initial begin : run
        int unsigned stop_at;
        int unsigned d;
        int unsigned l;
        int unsigned w;

        // click, double click, long press and an expiring window at reset values
        push_consume();
        push_update(1'b1, 0);
        push_update(1'b0, 10);
        push_update(1'b1, 10);
        push_update(1'b0, 10);
        push_update(1'b0, 70);
        push_update(1'b1, 100);
        push_update(1'b1, 60);
        push_consume();
        push_update(1'b0, 40);
        push_update(1'b0, 100);
        push_update(1'b1, 50);
        push_update(1'b1, 60);
        push_consume();
        push_update(1'b0, 90);
        push_update(1'b0, 100);
        push_update(1'b1, 1100);
        push_update(1'b1, 100);
        push_consume();
        push_update(1'b0, 100);
        push_update(1'b0, 100);
        push_update(1'b1, 100);
        push_update(1'b1, 60);
        push_update(1'b1, 340);
        push_consume();

        for (int ph = 0; ph < 10; ph++) begin
            case (ph)
                0: begin d = 0;     l = $urandom_range(20, 200); w = 0;     end
                1: begin d = 65535; l = 65535;                   w = 65535; end
                2: begin d = 0;     l = 0;                       w = 65535; end
                3: begin d = 65535; l = 0;                       w = 0;     end
                9: begin
                    d = bdcc_pkg::DEBOUNCE_RST;
                    l = bdcc_pkg::LONG_PRESS_RST;
                    w = bdcc_pkg::DOUBLE_WINDOW_RST;
                end
                default: begin
                    d = $urandom_range(1, 15);
                    l = $urandom_range(40, 200);
                    w = $urandom_range(20, 400);
                end
            endcase
            push_pause();
            push_setting(bdcc_pkg::CFG_DEBOUNCE, d);
            push_setting(bdcc_pkg::CFG_LONG_PRESS, l);
            push_setting(bdcc_pkg::CFG_DOUBLE_WINDOW, w);
            // take the timestamp across its wrap point
            if (ph == 5)
                clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
            stop_at = reqs_planned + 183;
            while (reqs_planned < stop_at) begin
                if ($urandom_range(0, 99) < 80)
                    add_gesture();
                else
                    add_noise();
            end
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (!stim_done || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("covered %0d requests (%0d consumes) over %0d register writes",
                 reqs_taken, consumes_taken, settings_written);
        $display("events returned: none %0d, click %0d, double %0d, long %0d",
                 events_returned[bdcc_pkg::EV_NONE], events_returned[bdcc_pkg::EV_CLICK],
                 events_returned[bdcc_pkg::EV_DOUBLE], events_returned[bdcc_pkg::EV_LONG]);
        if (fail_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

`default_nettype wire
